// File: sv/tts_pkg.sv
// ============================================================================
// tts_pkg
// Shared types, constants and the arctangent table for the tilt to servo
// pulse converter.
// ============================================================================
package tts_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    localparam int SCALE_SHIFT = 14;
    localparam int VEC_W       = SAMPLE_W + SCALE_SHIFT + 3;
    localparam int ACC_W       = 26;
    localparam int ANG_FRAC    = 16;
    localparam int ANG_W       = 24;

    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int PULSE_W     = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_SPAN = 2'd1;

    localparam logic [CFG_W-1:0] PULSE_MIN_RST  = 12'd500;
    localparam logic [CFG_W-1:0] PULSE_SPAN_RST = 12'd2000;

    localparam int DIV_CONST   = 180;
    localparam int PROD_W      = ANG_W + CFG_W;
    localparam int Q_W         = PROD_W - ANG_FRAC;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 21;
    localparam int QM_W        = Q_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_CONST);

    localparam logic signed [ACC_W-1:0] ANG_90  = ACC_W'(90 * (1 << ANG_FRAC));
    localparam logic signed [ACC_W-1:0] ANG_180 = ACC_W'(180 * (1 << ANG_FRAC));

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ACC_W-1:0] acc;
        logic                    zero;
    } t_vec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic int cordic_stages(input int steps);
        return (steps > TABLE_LEN) ? TABLE_LEN : steps;
    endfunction

    function automatic int pipe_latency(input int steps);
        return cordic_stages(steps) + 6;
    endfunction

    function automatic logic signed [ACC_W-1:0] atan_q16(input int idx);
        case (idx)
            0:       return ACC_W'(2949120);
            1:       return ACC_W'(1740967);
            2:       return ACC_W'(919879);
            3:       return ACC_W'(466945);
            4:       return ACC_W'(234379);
            5:       return ACC_W'(117304);
            6:       return ACC_W'(58666);
            7:       return ACC_W'(29335);
            8:       return ACC_W'(14668);
            9:       return ACC_W'(7334);
            10:      return ACC_W'(3667);
            11:      return ACC_W'(1833);
            12:      return ACC_W'(917);
            13:      return ACC_W'(458);
            14:      return ACC_W'(229);
            15:      return ACC_W'(115);
            16:      return ACC_W'(57);
            17:      return ACC_W'(29);
            18:      return ACC_W'(14);
            19:      return ACC_W'(7);
            20:      return ACC_W'(4);
            21:      return ACC_W'(2);
            22:      return ACC_W'(1);
            default: return '0;
        endcase
    endfunction

endpackage

// File: sv/tilt_to_servo_pulse_core.sv
// ============================================================================
// tilt_to_servo_pulse_core
// Converts an accelerometer X/Z sample pair into a servo pulse width.
// ============================================================================
// A sample pair is taken on any cycle where start is high and busy is low,
// one pair per cycle without gaps. The pulse width appears on
// o_pulse_width for one cycle with o_pulse_valid, in request order. Between
// request and result lie the CORDIC pipeline, one stage per iteration, the
// input register, the queue slot and four scaling stages. The receiver
// cannot stall the block. Configuration writes must be made only while no
// request is in flight; the block itself does not enforce it.
// ============================================================================
module tilt_to_servo_pulse_core #(
    parameter int CORDIC_STEPS = tts_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS  = tts_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [tts_pkg::SAMPLE_W-1:0] i_tilt_x,
    input  logic signed [tts_pkg::SAMPLE_W-1:0] i_tilt_z,
    output logic                                o_pulse_valid,
    output logic [tts_pkg::PULSE_W-1:0]         o_pulse_width,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tts_pkg::CFG_W-1:0]           i_cfg_data
);
    import tts_pkg::*;

    logic [CFG_W-1:0] r_pulse_min;
    logic [CFG_W-1:0] r_pulse_span;
    logic             r_cfg_ready;
    t_qstat           qstat;
    t_vec             front_vec;
    t_vec             head_vec;
    logic             front_push;
    logic             load;

    assign busy        = qstat.full;
    assign load        = start && !qstat.full;
    assign o_cfg_ready = r_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ready  <= 1'b0;
            r_pulse_min  <= PULSE_MIN_RST;
            r_pulse_span <= PULSE_SPAN_RST;
        end else begin
            r_cfg_ready <= 1'b1;
            if (i_cfg_valid && r_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PULSE_MIN:  r_pulse_min  <= i_cfg_data;
                    CFG_PULSE_SPAN: r_pulse_span <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    tts_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_tilt_x (i_tilt_x),
        .i_tilt_z (i_tilt_z),
        .i_qstat  (qstat),
        .o_vec    (front_vec),
        .o_valid  (front_push)
    );

    tts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_vec   (front_vec),
        .i_pop   (!qstat.empty),
        .o_vec   (head_vec),
        .o_qstat (qstat)
    );

    tts_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (!qstat.empty),
        .i_vec         (head_vec),
        .i_pulse_min   (r_pulse_min),
        .i_pulse_span  (r_pulse_span),
        .o_valid       (o_pulse_valid),
        .o_pulse_width (o_pulse_width)
    );

endmodule

// File: sv/tts_front.sv
// ============================================================================
// tts_front
// Accepts a sample pair, sign-extends and scales it, and turns the vector
// into the right half plane before the CORDIC pipeline.
// ============================================================================
module tts_front #(
    parameter int SAMPLE_BITS = tts_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic signed [tts_pkg::SAMPLE_W-1:0] i_tilt_x,
    input  logic signed [tts_pkg::SAMPLE_W-1:0] i_tilt_z,
    input  tts_pkg::t_qstat                    i_qstat,
    output tts_pkg::t_vec                      o_vec,
    output logic                               o_valid
);
    import tts_pkg::*;

    logic signed [SAMPLE_BITS-1:0] x_low;
    logic signed [SAMPLE_BITS-1:0] z_low;
    logic signed [VEC_W-1:0]       x_s;
    logic signed [VEC_W-1:0]       z_s;
    t_vec                          n_vec;
    t_vec                          r_vec;
    logic                          r_valid;
    logic                          push;

    assign x_low = i_tilt_x[SAMPLE_BITS-1:0];
    assign z_low = i_tilt_z[SAMPLE_BITS-1:0];
    assign x_s   = VEC_W'(x_low) <<< SCALE_SHIFT;
    assign z_s   = VEC_W'(z_low) <<< SCALE_SHIFT;
    assign push  = r_valid && !i_qstat.full;

    // The CORDIC works on y = X sample, x = Z sample.
    always_comb begin
        n_vec.zero = (x_low == '0) && (z_low == '0);
        n_vec.x    = z_s;
        n_vec.y    = x_s;
        n_vec.acc  = '0;
        if (z_s < 0) begin
            if (x_s >= 0) begin
                n_vec.x   = x_s;
                n_vec.y   = -z_s;
                n_vec.acc = ANG_90;
            end else begin
                n_vec.x   = -x_s;
                n_vec.y   = z_s;
                n_vec.acc = -ANG_90;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec   = r_vec;
    assign o_valid = push;

endmodule

// File: sv/tts_queue.sv
// ============================================================================
// tts_queue
// Two-entry queue between the front and the CORDIC pipeline.
// ============================================================================
module tts_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tts_pkg::t_vec   i_vec,
    input  logic            i_pop,
    output tts_pkg::t_vec   o_vec,
    output tts_pkg::t_qstat o_qstat
);
    import tts_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_vec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             full;
    logic             empty;
    logic             do_push;
    logic             do_pop;

    assign full    = (r_count == (PTR_W + 1)'(DEPTH));
    assign empty   = (r_count == '0);
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_vec;
        end
    end

    assign o_vec         = r_mem[r_rd_ptr];
    assign o_qstat.full  = full;
    assign o_qstat.empty = empty;

endmodule

// File: sv/tts_back.sv
// ============================================================================
// tts_back
// CORDIC vectoring pipeline, one stage per iteration, followed by the angle
// clamp and the scaling of the angle into a pulse width.
// ============================================================================
module tts_back #(
    parameter int CORDIC_STEPS = tts_pkg::CORDIC_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  tts_pkg::t_vec               i_vec,
    input  logic [tts_pkg::CFG_W-1:0]   i_pulse_min,
    input  logic [tts_pkg::CFG_W-1:0]   i_pulse_span,
    output logic                        o_valid,
    output logic [tts_pkg::PULSE_W-1:0] o_pulse_width
);
    import tts_pkg::*;

    localparam int STEPS = cordic_stages(CORDIC_STEPS);

    logic signed [VEC_W-1:0] r_x    [STEPS];
    logic signed [VEC_W-1:0] r_y    [STEPS];
    logic signed [ACC_W-1:0] r_acc  [STEPS];
    logic                    r_zero [STEPS];
    logic                    r_vld  [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        logic signed [VEC_W-1:0] x_in;
        logic signed [VEC_W-1:0] y_in;
        logic signed [ACC_W-1:0] a_in;
        logic                    z_in;
        logic                    v_in;
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;

        if (i == 0) begin : g_first
            assign x_in = i_vec.x;
            assign y_in = i_vec.y;
            assign a_in = i_vec.acc;
            assign z_in = i_vec.zero;
            assign v_in = i_valid;
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign a_in = r_acc[i-1];
            assign z_in = r_zero[i-1];
            assign v_in = r_vld[i-1];
        end

        assign xs = x_in >>> i;
        assign ys = y_in >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else begin
                r_vld[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_zero[i] <= z_in;
            if (y_in >= 0) begin
                r_x[i]   <= x_in + ys;
                r_y[i]   <= y_in - xs;
                r_acc[i] <= a_in + atan_q16(i);
            end else begin
                r_x[i]   <= x_in - ys;
                r_y[i]   <= y_in + xs;
                r_acc[i] <= a_in - atan_q16(i);
            end
        end
    end

    logic signed [ACC_W-1:0]   ang_sum;
    logic [ANG_W-1:0]          n_ang;
    logic [ANG_W-1:0]          r_ang;
    logic [PROD_W-1:0]         prod;
    logic [Q_W-1:0]            r_q;
    logic [Q_W-1:0]            r_q2;
    logic [QM_W-1:0]           r_qm;
    logic [PULSE_W-1:0]        est;
    logic [Q_W:0]              est_x;
    logic [Q_W:0]              rem;
    logic [PULSE_W-1:0]        quot;
    logic [PULSE_W-1:0]        r_pulse;
    logic [3:0]                r_pv;

    assign ang_sum = r_zero[STEPS-1] ? ANG_90 : r_acc[STEPS-1] + ANG_90;

    always_comb begin
        if (ang_sum < 0) begin
            n_ang = '0;
        end else if (ang_sum > ANG_180) begin
            n_ang = ANG_180[ANG_W-1:0];
        end else begin
            n_ang = ang_sum[ANG_W-1:0];
        end
    end

    assign prod  = PROD_W'(r_ang) * PROD_W'(i_pulse_span);
    assign est   = r_qm[QM_W-1:RECIP_SHIFT];
    assign est_x = (Q_W + 1)'(est) * (Q_W + 1)'(DIV_CONST);
    assign rem   = (Q_W + 1)'(r_q2) - est_x;
    assign quot  = (rem >= (Q_W + 1)'(DIV_CONST)) ? est + 1'b1 : est;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            r_pv <= {r_pv[2:0], r_vld[STEPS-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang   <= n_ang;
        r_q     <= prod[PROD_W-1:ANG_FRAC];
        r_q2    <= r_q;
        r_qm    <= QM_W'(r_q) * QM_W'(RECIP);
        r_pulse <= PULSE_W'(i_pulse_min) + quot;
    end

    assign o_valid       = r_pv[3];
    assign o_pulse_width = r_pulse;

endmodule

// File: sv/tts_checker.sv
// ============================================================================
// tts_checker
// Port-level checks for the tilt to servo pulse converter.
// ============================================================================
module tts_checker #(
    parameter int CORDIC_STEPS = tts_pkg::CORDIC_STEPS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_pulse_valid,
    input logic [tts_pkg::PULSE_W-1:0] o_pulse_width
);
    import tts_pkg::*;

    localparam int LAT = pipe_latency(CORDIC_STEPS);

    // Every request yields exactly one result after the fixed latency.
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_pulse_valid)
        else $error("request did not produce a result on time");

    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pulse_valid |-> $past(start && !busy, LAT))
        else $error("result without a matching request");

    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pulse_valid |-> (o_pulse_width <= 13'd8190))
        else $error("pulse width out of range");

    // The pipeline never stalls, so the queue never fills.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("input side stalled");

endmodule

bind tilt_to_servo_pulse_core tts_checker #(
    .CORDIC_STEPS (CORDIC_STEPS)
) u_tts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_pulse_valid (o_pulse_valid),
    .o_pulse_width (o_pulse_width)
);
